/* rtl/lswc_pkg.sv */
package lswc_pkg;

	// Width of every coordinate field and window register.
	localparam int COORD_W = 12;
	// Default fraction width of the clip parameters.
	localparam int FRAC_BITS_DEF = 16;
	// Width of the register index on the configuration port.
	localparam int CFG_IDX_W = 2;
	// Four divider lanes: entering and leaving parameter for each axis.
	localparam int LANES = 4;
	localparam int LANE_EX = 0;
	localparam int LANE_LX = 1;
	localparam int LANE_EY = 2;
	localparam int LANE_LY = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_LEFT   = 2'd0,
		REG_WIN_BOTTOM = 2'd1,
		REG_WIN_RIGHT  = 2'd2,
		REG_WIN_TOP    = 2'd3
	} cfg_reg_t;

	localparam logic signed [COORD_W-1:0] WIN_LEFT_RST   = COORD_W'(0);
	localparam logic signed [COORD_W-1:0] WIN_BOTTOM_RST = COORD_W'(0);
	localparam logic signed [COORD_W-1:0] WIN_RIGHT_RST  = COORD_W'(1023);
	localparam logic signed [COORD_W-1:0] WIN_TOP_RST    = COORD_W'(1023);

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} in_t;

	typedef struct packed {
		logic                      visible;
		logic signed [COORD_W-1:0] clip_start_x;
		logic signed [COORD_W-1:0] clip_start_y;
		logic signed [COORD_W-1:0] clip_end_x;
		logic signed [COORD_W-1:0] clip_end_y;
	} out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] top;
	} win_t;

	// Segment data that rides alongside the divider lanes.
	typedef struct packed {
		logic                      reject;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W:0]   dx;
		logic signed [COORD_W:0]   dy;
	} side_t;

endpackage

/* rtl/line_segment_window_clipper.sv */
// Channel   Ports                              Transaction when
// input     start, busy, item                  start high and busy low at clk rise
// result    done, result                       done high for one cycle
// config    cfg_we, cfg_index, cfg_data        cfg_we high at clk rise
//
// One segment is taken every cycle; busy stays low.
// Stages in order: setup, numerator, one divider stage per quotient bit
// (FRAC_BITS + 1), select, multiply and round/output.
// The divider pipeline sets the depth; all four quotients run in parallel lanes.
// Reset clears the valid bits and loads the default window; no result is lost
// only if the receiver takes every strobe, which the block itself does not enforce.
module line_segment_window_clipper #(
	parameter int FRAC_BITS = lswc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  lswc_pkg::in_t                   item,
	output logic                            done,
	output lswc_pkg::out_t                  result,
	input  logic                            cfg_we,
	input  logic [lswc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lswc_pkg::COORD_W-1:0]    cfg_data
);
	import lswc_pkg::*;

	localparam int LAT = FRAC_BITS + 6;

	win_t win_q;

	logic               valid_s1;
	side_t              side_s1;
	logic [COORD_W-1:0] num_s1 [LANES];
	logic [COORD_W-1:0] den_s1 [LANES];

	logic               div_valid;
	side_t              div_side;
	logic [FRAC_BITS:0] div_quo [LANES];

	assign busy = 1'b0;

	// Window register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= WIN_LEFT_RST;
			win_q.bottom <= WIN_BOTTOM_RST;
			win_q.right  <= WIN_RIGHT_RST;
			win_q.top    <= WIN_TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIN_LEFT:   win_q.left   <= cfg_data;
				REG_WIN_BOTTOM: win_q.bottom <= cfg_data;
				REG_WIN_RIGHT:  win_q.right  <= cfg_data;
				REG_WIN_TOP:    win_q.top    <= cfg_data;
				default: ;
			endcase
		end
	end

	lswc_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !busy),
		.item     (item),
		.win      (win_q),
		.valid_s1 (valid_s1),
		.side_s1  (side_s1),
		.num_s1   (num_s1),
		.den_s1   (den_s1)
	);

	lswc_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (valid_s1),
		.side_i  (side_s1),
		.num_i   (num_s1),
		.den_i   (den_s1),
		.valid_o (div_valid),
		.side_o  (div_side),
		.quo_o   (div_quo)
	);

	lswc_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (div_valid),
		.side_i  (div_side),
		.quo_i   (div_quo),
		.done    (done),
		.result  (result)
	);

	// Every transaction yields exactly one result at the end of the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without a transaction");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.visible) |-> (result.clip_start_x == '0
			&& result.clip_start_y == '0 && result.clip_end_x == '0
			&& result.clip_end_y == '0))
		else $error("rejected segment with nonzero coordinates");

endmodule

/* rtl/lswc_setup.sv */
module lswc_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lswc_pkg::in_t                 item,
	input  lswc_pkg::win_t                win,
	output logic                          valid_s1,
	output lswc_pkg::side_t               side_s1,
	output logic [lswc_pkg::COORD_W-1:0]  num_s1 [lswc_pkg::LANES],
	output logic [lswc_pkg::COORD_W-1:0]  den_s1 [lswc_pkg::LANES]
);
	import lswc_pkg::*;

	typedef struct packed {
		logic               rej;
		logic [COORD_W-1:0] a_e;
		logic [COORD_W-1:0] a_l;
		logic [COORD_W-1:0] m;
	} axis_t;

	// Per-axis Liang-Barsky setup: reject flags and divider operands.
	function automatic axis_t clip_axis(logic signed [COORD_W-1:0] s,
			logic signed [COORD_W:0] d, logic signed [COORD_W-1:0] lo,
			logic signed [COORD_W-1:0] hi);
		logic signed [COORD_W:0] q_lo;
		logic signed [COORD_W:0] q_hi;
		logic signed [COORD_W:0] e;
		logic signed [COORD_W:0] l;
		logic signed [COORD_W:0] mag;
		logic signed [COORD_W:0] ne;
		axis_t r;
		q_lo = $signed({s[COORD_W-1], s}) - $signed({lo[COORD_W-1], lo});
		q_hi = $signed({hi[COORD_W-1], hi}) - $signed({s[COORD_W-1], s});
		r = '0;
		if (d == '0) begin
			// Parallel to this axis: only the bound test matters.
			r.rej = q_lo[COORD_W] | q_hi[COORD_W];
			r.m   = COORD_W'(1);
			r.a_l = COORD_W'(1);
		end else begin
			mag = d[COORD_W] ? -d : d;
			r.m = mag[COORD_W-1:0];
			e   = d[COORD_W] ? q_hi : q_lo;
			l   = d[COORD_W] ? q_lo : q_hi;
			ne  = -e;
			if (e[COORD_W]) begin
				if (ne > mag) begin
					r.rej = 1'b1;
				end
				r.a_e = ne[COORD_W-1:0];
			end
			if (l[COORD_W]) begin
				r.rej = 1'b1;
			end else if (l >= mag) begin
				r.a_l = mag[COORD_W-1:0];
			end else begin
				r.a_l = l[COORD_W-1:0];
			end
		end
		return r;
	endfunction

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	axis_t ax;
	axis_t ay;

	always_comb begin
		dx = $signed({item.end_x[COORD_W-1], item.end_x})
			- $signed({item.start_x[COORD_W-1], item.start_x});
		dy = $signed({item.end_y[COORD_W-1], item.end_y})
			- $signed({item.start_y[COORD_W-1], item.start_y});
		ax = clip_axis(item.start_x, dx, win.left, win.right);
		ay = clip_axis(item.start_y, dy, win.bottom, win.top);
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		side_s1.reject   <= ax.rej | ay.rej;
		side_s1.sx       <= item.start_x;
		side_s1.sy       <= item.start_y;
		side_s1.dx       <= dx;
		side_s1.dy       <= dy;
		num_s1[LANE_EX]  <= ax.a_e;
		den_s1[LANE_EX]  <= ax.m;
		num_s1[LANE_LX]  <= ax.a_l;
		den_s1[LANE_LX]  <= ax.m;
		num_s1[LANE_EY]  <= ay.a_e;
		den_s1[LANE_EY]  <= ay.m;
		num_s1[LANE_LY]  <= ay.a_l;
		den_s1[LANE_LY]  <= ay.m;
	end

endmodule

/* rtl/lswc_div_pipe.sv */
module lswc_div_pipe #(
	parameter int FRAC_BITS = lswc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_i,
	input  lswc_pkg::side_t               side_i,
	input  logic [lswc_pkg::COORD_W-1:0]  num_i [lswc_pkg::LANES],
	input  logic [lswc_pkg::COORD_W-1:0]  den_i [lswc_pkg::LANES],
	output logic                          valid_o,
	output lswc_pkg::side_t               side_o,
	output logic [FRAC_BITS:0]            quo_o [lswc_pkg::LANES]
);
	import lswc_pkg::*;

	localparam int QW  = FRAC_BITS + 1;
	localparam int DW  = COORD_W + FRAC_BITS + 2;
	localparam int NST = QW;
	localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

	logic               valid_s [0:NST];
	side_t              side_s  [0:NST];
	logic [DW-1:0]      rem_s   [0:NST][LANES];
	logic [COORD_W-1:0] den_s   [0:NST][LANES];
	logic [QW-1:0]      quo_s   [0:NST][LANES];

	// Stage zero forms the rounding numerator 2*a*ONE + m.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_i;
		for (int i = 0; i < LANES; i++) begin
			rem_s[0][i] <= (DW'(num_i[i]) << QW) + DW'(den_i[i]);
			den_s[0][i] <= den_i[i];
			quo_s[0][i] <= '0;
		end
	end

	// One restoring quotient bit per stage, most significant first.
	for (genvar j = 1; j <= NST; j++) begin : g_stage
		localparam int K = QW - j;
		logic [DW-1:0] trial [LANES];
		logic          take  [LANES];

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				trial[i] = DW'(den_s[j-1][i]) << (K + 1);
				take[i]  = rem_s[j-1][i] >= trial[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			side_s[j] <= side_s[j-1];
			for (int i = 0; i < LANES; i++) begin
				den_s[j][i] <= den_s[j-1][i];
				rem_s[j][i] <= take[i] ? rem_s[j-1][i] - trial[i] : rem_s[j-1][i];
				quo_s[j][i] <= quo_s[j-1][i] | (take[i] ? QW'(1) << K : '0);
			end
		end
	end

	assign valid_o = valid_s[NST];
	assign side_o  = side_s[NST];
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			quo_o[i] = quo_s[NST][i];
		end
	end

	// A rounded fraction of a/m with a <= m never exceeds one. A rejected
	// segment may carry an entering numerator above its divisor.
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_o && !side_o.reject) |-> (quo_o[LANE_EX] <= ONE && quo_o[LANE_LX] <= ONE
			&& quo_o[LANE_EY] <= ONE && quo_o[LANE_LY] <= ONE))
		else $error("divider quotient above one");

	// The entering-x remainder after the last bit is below the doubled divisor.
	a_rem_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_o && !side_o.reject)
			|-> (rem_s[NST][LANE_EX] < (DW'(den_s[NST][LANE_EX]) << 1)))
		else $error("divider remainder out of range");

endmodule

/* rtl/lswc_interp.sv */
module lswc_interp #(
	parameter int FRAC_BITS = lswc_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_i,
	input  lswc_pkg::side_t     side_i,
	input  logic [FRAC_BITS:0]  quo_i [lswc_pkg::LANES],
	output logic                done,
	output lswc_pkg::out_t      result
);
	import lswc_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int PW = COORD_W + 1 + QW + 1;
	localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

	logic          valid_s1;
	side_t         side_s1;
	logic [QW-1:0] u1_s1;
	logic [QW-1:0] u2_s1;
	logic [QW-1:0] u1;
	logic [QW-1:0] u2;

	logic                 valid_s2;
	side_t                side_s2;
	logic signed [PW-1:0] prod_s2 [4];

	logic signed [PW:0]      v     [4];
	logic        [COORD_W-1:0] coord [4];

	// Largest entering and smallest leaving parameter.
	always_comb begin
		u1 = (quo_i[LANE_EX] > quo_i[LANE_EY]) ? quo_i[LANE_EX] : quo_i[LANE_EY];
		u2 = (quo_i[LANE_LX] < quo_i[LANE_LY]) ? quo_i[LANE_LX] : quo_i[LANE_LY];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	// Parameter select, then the four products.
	always_ff @(posedge clk) begin
		side_s1.reject <= side_i.reject | (u1 > u2);
		side_s1.sx     <= side_i.sx;
		side_s1.sy     <= side_i.sy;
		side_s1.dx     <= side_i.dx;
		side_s1.dy     <= side_i.dy;
		u1_s1          <= u1;
		u2_s1          <= u2;
		side_s2        <= side_s1;
		prod_s2[0]     <= PW'(side_s1.dx) * PW'($signed({1'b0, u1_s1}));
		prod_s2[1]     <= PW'(side_s1.dy) * PW'($signed({1'b0, u1_s1}));
		prod_s2[2]     <= PW'(side_s1.dx) * PW'($signed({1'b0, u2_s1}));
		prod_s2[3]     <= PW'(side_s1.dy) * PW'($signed({1'b0, u2_s1}));
	end

	// Round half up, add the start point, blank rejected segments.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			v[i] = $signed({prod_s2[i][PW-1], prod_s2[i]}) + HALF;
		end
		coord[0] = side_s2.sx + v[0][FRAC_BITS+COORD_W-1:FRAC_BITS];
		coord[1] = side_s2.sy + v[1][FRAC_BITS+COORD_W-1:FRAC_BITS];
		coord[2] = side_s2.sx + v[2][FRAC_BITS+COORD_W-1:FRAC_BITS];
		coord[3] = side_s2.sy + v[3][FRAC_BITS+COORD_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		result.visible      <= !side_s2.reject;
		result.clip_start_x <= side_s2.reject ? '0 : coord[0];
		result.clip_start_y <= side_s2.reject ? '0 : coord[1];
		result.clip_end_x   <= side_s2.reject ? '0 : coord[2];
		result.clip_end_y   <= side_s2.reject ? '0 : coord[3];
	end

	// A segment kept past the select stage has ordered parameters.
	a_param_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !side_s1.reject) |-> (u1_s1 <= u2_s1))
		else $error("entering parameter beyond leaving parameter");

endmodule
